FILE: sv/gup_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the gamma / unary bit packer
// no dependencies

package gup_pkg;

   typedef enum logic [1:0] {
      ACT_GAMMA = 2'd0,
      ACT_UNARY = 2'd1,
      ACT_FLUSH = 2'd2
   } action_type;

   // next bit goes into the msb of the open byte
   localparam logic [2:0] BIT_TOP = 3'd7;

   typedef struct packed {
      logic load;
      logic search;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic found;
      logic completes;
      logic done;
      logic out_free;
   } status_type;

endpackage

FILE: sv/gamma_unary_bit_packer.sv
`timescale 1ns / 1ps
// top level of the gamma / unary bit packer: controller plus datapath
// depends on gup_pkg, gup_ctrl, gup_dp
//
// channel   dir  transfer                  payload
// req_*     in   req_tvalid & req_tready   tuser = action, tdata = code_value
// rsp_*     out  rsp_tvalid & rsp_tready   tdata = out_byte, tlast = last_of_run,
//                                          tuser = final_byte
//
// one item at a time: the item is taken while idle, then a gamma code runs an msb
// search over eight value bits at a time (from the top), then fills each byte the
// code touches; unary and flush go straight to the fill; the open-byte fill of up to
// eight bits per cycle sets the rate while the output register is free
// reset clears the open byte and sets the next bit to the msb
// a full output register holds the fill step that would complete another byte

module gamma_unary_bit_packer #(
   parameter int MAX_UNARY   = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] code_value
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser    // [0] final_byte
);

   gup_pkg::cmd_type    cmd;
   gup_pkg::status_type status;

   gup_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gup_dp #(
      .MAX_UNARY   (MAX_UNARY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: sv/gup_ctrl.sv
`timescale 1ns / 1ps
// controller state machine for the bit packer
// depends on gup_pkg

module gup_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic [1:0]         req_action,
   output logic               req_tready,
   input  gup_pkg::status_type status,
   output gup_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RUN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_action == gup_pkg::ACT_GAMMA) begin
                  state_in = ST_SEARCH;
               end else if (req_action == gup_pkg::ACT_UNARY ||
                            req_action == gup_pkg::ACT_FLUSH) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.found) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = !status.completes || status.out_free;
            if (cmd.step && status.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/gup_dp.sv
`timescale 1ns / 1ps
// datapath of the bit packer: code registers, msb search, byte chunk fill, output register
// depends on gup_pkg

module gup_dp #(
   parameter int MAX_UNARY   = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  gup_pkg::cmd_type    cmd,
   output gup_pkg::status_type status,
   input  logic [31:0]         req_tdata,
   input  logic [1:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic [0:0]          rsp_tuser
);

   localparam int CW = $clog2(MAX_UNARY + 2 * VALUE_WIDTH + 8);
   localparam int EW = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   flush_ff, flush_in;
   logic [CW-1:0]          ones_ff, ones_in;
   logic [EW-1:0]          sfx_ff, sfx_in;
   logic [CW-1:0]          len_ff, len_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [EW-1:0]          srch_ff, srch_in;
   logic [7:0]             partial_ff, partial_in;
   logic [2:0]             bitpos_ff, bitpos_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;
   logic                   final_ff, final_in;

   logic [VALUE_WIDTH-1:0] v_raw;
   logic [VALUE_WIDTH-1:0] v_nz;
   logic                   sat;
   logic [CW-1:0]          u_len;
   logic                   hit;
   logic [EW-1:0]          e_hit;
   logic [7:0]             chunk;
   logic [7:0]             fchunk;
   logic [CW-1:0]          rem;
   logic [3:0]             avail;
   logic                   completes;
   logic                   done;
   logic                   is_last;
   logic                   emit;

   // input value, zero taken as one, unary length saturated
   always_comb begin
      v_raw = req_tdata[VALUE_WIDTH-1:0];
      v_nz  = (v_raw == '0) ? VALUE_WIDTH'(1) : v_raw;
      sat   = 33'(v_nz) > 33'(MAX_UNARY);
      u_len = sat ? CW'(MAX_UNARY) : CW'(v_nz);
   end

   // msb search, eight bits of the value per cycle
   always_comb begin
      hit   = 1'b0;
      e_hit = '0;
      for (int j = 7; j >= 0; j--) begin
         if (int'(srch_ff) >= j && value_ff[srch_ff - EW'(j)]) begin
            hit   = 1'b1;
            e_hit = srch_ff - EW'(j);
         end
      end
   end

   // bits of the open byte from bitpos down, one lane per bit position
   always_comb begin : lanes
      logic [CW-1:0] k;
      logic [CW-1:0] d;
      chunk  = '0;
      fchunk = '0;
      k      = '0;
      d      = '0;
      for (int p = 0; p < 8; p++) begin
         k = idx_ff + CW'(bitpos_ff) - CW'(p);
         d = ones_ff + CW'(sfx_ff) - k;
         fchunk[p] = p < int'(bitpos_ff);
         if (p <= int'(bitpos_ff) && k < len_ff) begin
            if (k < ones_ff) begin
               chunk[p] = 1'b1;
            end else if (k == ones_ff) begin
               chunk[p] = 1'b0;
            end else begin
               chunk[p] = value_ff[d[EW-1:0]];
            end
         end
      end
   end

   always_comb begin
      rem       = len_ff - idx_ff;
      avail     = {1'b0, bitpos_ff} + 4'd1;
      completes = flush_ff || (rem >= CW'(avail));
      done      = flush_ff || (rem <= CW'(avail));
      is_last   = flush_ff || ((rem - CW'(avail)) < CW'(8));
      emit      = cmd.step && completes;
   end

   always_comb begin
      status.found     = hit;
      status.completes = completes;
      status.done      = done;
      status.out_free  = !valid_ff || rsp_tready;
   end

   always_comb begin
      value_in   = value_ff;
      flush_in   = flush_ff;
      ones_in    = ones_ff;
      sfx_in     = sfx_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      srch_in    = srch_ff;
      partial_in = partial_ff;
      bitpos_in  = bitpos_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      final_in   = final_ff;
      valid_in   = valid_ff && !rsp_tready;

      if (cmd.load) begin
         value_in = v_nz;
         flush_in = req_tuser == gup_pkg::ACT_FLUSH;
         idx_in   = '0;
         srch_in  = EW'(VALUE_WIDTH - 1);
         ones_in  = u_len - CW'(1);
         sfx_in   = '0;
         len_in   = u_len;
      end

      if (cmd.search) begin
         if (hit) begin
            ones_in = CW'(e_hit);
            sfx_in  = e_hit;
            len_in  = CW'(e_hit) + CW'(e_hit) + CW'(1);
         end else begin
            srch_in = srch_ff - EW'(8);
         end
      end

      if (cmd.step) begin
         if (flush_ff) begin
            byte_in    = partial_ff | fchunk;
            last_in    = 1'b1;
            final_in   = 1'b1;
            partial_in = '0;
            bitpos_in  = gup_pkg::BIT_TOP;
         end else if (completes) begin
            byte_in    = partial_ff | chunk;
            last_in    = is_last;
            final_in   = 1'b0;
            partial_in = '0;
            bitpos_in  = gup_pkg::BIT_TOP;
            idx_in     = idx_ff + CW'(avail);
         end else begin
            partial_in = partial_ff | chunk;
            bitpos_in  = bitpos_ff - rem[2:0];
            idx_in     = len_ff;
         end
      end

      if (emit) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         partial_ff <= '0;
         bitpos_ff  <= gup_pkg::BIT_TOP;
         flush_ff   <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         partial_ff <= partial_in;
         bitpos_ff  <= bitpos_in;
         flush_ff   <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      ones_ff  <= ones_in;
      sfx_ff   <= sfx_in;
      len_ff   <= len_in;
      idx_ff   <= idx_in;
      srch_ff  <= srch_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      final_ff <= final_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = byte_ff;
   assign rsp_tlast    = last_ff;
   assign rsp_tuser[0] = final_ff;

endmodule

FILE: sv/gup_checker.sv
`timescale 1ns / 1ps
// port-level checks for the bit packer, bound to the top level
// depends on gup_pkg, gamma_unary_bit_packer

module gup_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // padded flush byte always closes its run
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("flush byte not marked last");

   // taking a gamma, unary or flush item closes the input in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      (req_tuser == gup_pkg::ACT_GAMMA || req_tuser == gup_pkg::ACT_UNARY ||
       req_tuser == gup_pkg::ACT_FLUSH) |=> !req_tready)
      else $error("input taken while busy");

endmodule

bind gamma_unary_bit_packer gup_checker u_gup_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
